// ----- rtl/coas_pkg.sv -----
// ----------------------------------------------------------------------------
// coas_pkg
// Shared codes and record types of the operand address sequencer.
// ----------------------------------------------------------------------------
package coas_pkg;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [3:0] MODE_IMP  = 4'd0;
    localparam logic [3:0] MODE_ACC  = 4'd1;
    localparam logic [3:0] MODE_IMM  = 4'd2;
    localparam logic [3:0] MODE_ZP   = 4'd3;
    localparam logic [3:0] MODE_ZPX  = 4'd4;
    localparam logic [3:0] MODE_ZPY  = 4'd5;
    localparam logic [3:0] MODE_REL  = 4'd6;
    localparam logic [3:0] MODE_ABS  = 4'd7;
    localparam logic [3:0] MODE_ABSX = 4'd8;
    localparam logic [3:0] MODE_ABSY = 4'd9;
    localparam logic [3:0] MODE_IND  = 4'd10;
    localparam logic [3:0] MODE_INDX = 4'd11;
    localparam logic [3:0] MODE_INDY = 4'd12;

    localparam logic [1:0] STATUS_REQ  = 2'd0;
    localparam logic [1:0] STATUS_DONE = 2'd1;
    localparam logic [1:0] STATUS_ERR  = 2'd2;

    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD  = 2'd2;
    localparam logic [1:0] STEP_FOURTH = 2'd3;

    localparam logic [15:0] HIGH_MASK = 16'hFF00;

    typedef struct packed {
        logic        busy;
        logic [3:0]  mode;
        logic [1:0]  step;
        logic [15:0] pc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  low;
        logic [15:0] ptr;
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] bus_address;
        logic [15:0] effective_address;
        logic        address_valid;
        logic [15:0] next_pc;
        logic        page_crossed;
        logic        accumulator_mode;
    } result_t;

endpackage

// ----- rtl/coas_step.sv -----
// ----------------------------------------------------------------------------
// coas_step
// Next-state and result logic for one start or read-data transfer.
// ----------------------------------------------------------------------------
module coas_step
(
    input  coas_pkg::seq_state_t st,
    input  logic                 kind,
    input  logic [3:0]           mode,
    input  logic [15:0]          pc_in,
    input  logic [7:0]           x_index,
    input  logic [7:0]           y_index,
    input  logic [7:0]           read_byte,
    output coas_pkg::seq_state_t st_next,
    output coas_pkg::result_t    res
);

    logic [15:0] pc1;
    logic [15:0] pc2;
    logic [15:0] base;
    logic [7:0]  index;
    logic [15:0] indexed;
    logic [15:0] rel_target;
    logic [7:0]  zp_x;
    logic [7:0]  zp_y;
    logic [7:0]  ptr_inc;

    assign pc1        = st.pc + 16'd1;
    assign pc2        = st.pc + 16'd2;
    assign base       = {read_byte, st.low};
    assign index      = (st.mode == coas_pkg::MODE_ABSX) ? st.x : st.y;
    assign indexed    = base + {8'd0, index};
    assign rel_target = pc1 + {{8{read_byte[7]}}, read_byte};
    assign zp_x       = read_byte + st.x;
    assign zp_y       = read_byte + st.y;
    assign ptr_inc    = st.ptr[7:0] + 8'd1;

    always_comb
    begin
        st_next    = st;
        res        = '0;
        res.status = coas_pkg::STATUS_ERR;
        if (kind == coas_pkg::KIND_START) begin
            if (!st.busy) begin
                case (mode)
                    coas_pkg::MODE_IMP:
                    begin
                        res.status  = coas_pkg::STATUS_DONE;
                        res.next_pc = pc_in;
                    end
                    coas_pkg::MODE_ACC:
                    begin
                        res.status           = coas_pkg::STATUS_DONE;
                        res.next_pc          = pc_in;
                        res.accumulator_mode = 1'b1;
                    end
                    coas_pkg::MODE_IMM:
                    begin
                        res.status            = coas_pkg::STATUS_DONE;
                        res.effective_address = pc_in;
                        res.address_valid     = 1'b1;
                        res.next_pc           = pc_in + 16'd1;
                    end
                    coas_pkg::MODE_ZP, coas_pkg::MODE_ZPX, coas_pkg::MODE_ZPY,
                    coas_pkg::MODE_REL, coas_pkg::MODE_ABS, coas_pkg::MODE_ABSX,
                    coas_pkg::MODE_ABSY, coas_pkg::MODE_IND, coas_pkg::MODE_INDX,
                    coas_pkg::MODE_INDY:
                    begin
                        st_next.busy    = 1'b1;
                        st_next.mode    = mode;
                        st_next.step    = coas_pkg::STEP_FIRST;
                        st_next.pc      = pc_in;
                        st_next.x       = x_index;
                        st_next.y       = y_index;
                        st_next.low     = 8'd0;
                        st_next.ptr     = 16'd0;
                        res.status      = coas_pkg::STATUS_REQ;
                        res.bus_address = pc_in;
                    end
                    default:
                    begin
                        res.status = coas_pkg::STATUS_ERR;
                    end
                endcase
            end
        end else if (st.busy) begin
            case (st.mode)
                coas_pkg::MODE_ZP, coas_pkg::MODE_ZPX, coas_pkg::MODE_ZPY:
                begin
                    st_next.busy          = 1'b0;
                    res.status            = coas_pkg::STATUS_DONE;
                    res.address_valid     = 1'b1;
                    res.next_pc           = pc1;
                    if (st.mode == coas_pkg::MODE_ZPX) begin
                        res.effective_address = {8'd0, zp_x};
                    end else if (st.mode == coas_pkg::MODE_ZPY) begin
                        res.effective_address = {8'd0, zp_y};
                    end else begin
                        res.effective_address = {8'd0, read_byte};
                    end
                end
                coas_pkg::MODE_REL:
                begin
                    st_next.busy          = 1'b0;
                    res.status            = coas_pkg::STATUS_DONE;
                    res.address_valid     = 1'b1;
                    res.next_pc           = pc1;
                    res.effective_address = rel_target;
                end
                coas_pkg::MODE_ABS, coas_pkg::MODE_ABSX, coas_pkg::MODE_ABSY:
                begin
                    if (st.step == coas_pkg::STEP_FIRST) begin
                        st_next.low     = read_byte;
                        st_next.step    = coas_pkg::STEP_SECOND;
                        res.status      = coas_pkg::STATUS_REQ;
                        res.bus_address = pc1;
                    end else begin
                        st_next.busy      = 1'b0;
                        res.status        = coas_pkg::STATUS_DONE;
                        res.address_valid = 1'b1;
                        res.next_pc       = pc2;
                        if (st.mode == coas_pkg::MODE_ABS) begin
                            res.effective_address = base;
                        end else begin
                            res.effective_address = indexed;
                            res.page_crossed = (indexed & coas_pkg::HIGH_MASK)
                                               != (base & coas_pkg::HIGH_MASK);
                        end
                    end
                end
                coas_pkg::MODE_IND:
                begin
                    case (st.step)
                        coas_pkg::STEP_FIRST:
                        begin
                            st_next.low     = read_byte;
                            st_next.step    = coas_pkg::STEP_SECOND;
                            res.status      = coas_pkg::STATUS_REQ;
                            res.bus_address = pc1;
                        end
                        coas_pkg::STEP_SECOND:
                        begin
                            st_next.ptr     = base;
                            st_next.step    = coas_pkg::STEP_THIRD;
                            res.status      = coas_pkg::STATUS_REQ;
                            res.bus_address = base;
                        end
                        coas_pkg::STEP_THIRD:
                        begin
                            st_next.low     = read_byte;
                            st_next.step    = coas_pkg::STEP_FOURTH;
                            res.status      = coas_pkg::STATUS_REQ;
                            res.bus_address = st.ptr + 16'd1;
                        end
                        default:
                        begin
                            st_next.busy          = 1'b0;
                            res.status            = coas_pkg::STATUS_DONE;
                            res.address_valid     = 1'b1;
                            res.next_pc           = pc2;
                            res.effective_address = base;
                        end
                    endcase
                end
                coas_pkg::MODE_INDX, coas_pkg::MODE_INDY:
                begin
                    case (st.step)
                        coas_pkg::STEP_FIRST:
                        begin
                            if (st.mode == coas_pkg::MODE_INDX) begin
                                st_next.ptr     = {8'd0, zp_x};
                                res.bus_address = {8'd0, zp_x};
                            end else begin
                                st_next.ptr     = {8'd0, read_byte};
                                res.bus_address = {8'd0, read_byte};
                            end
                            st_next.step = coas_pkg::STEP_SECOND;
                            res.status   = coas_pkg::STATUS_REQ;
                        end
                        coas_pkg::STEP_SECOND:
                        begin
                            st_next.low     = read_byte;
                            st_next.step    = coas_pkg::STEP_THIRD;
                            res.status      = coas_pkg::STATUS_REQ;
                            res.bus_address = {8'd0, ptr_inc};
                        end
                        default:
                        begin
                            st_next.busy      = 1'b0;
                            res.status        = coas_pkg::STATUS_DONE;
                            res.address_valid = 1'b1;
                            res.next_pc       = pc1;
                            if (st.mode == coas_pkg::MODE_INDX) begin
                                res.effective_address = base;
                            end else begin
                                res.effective_address = indexed;
                                res.page_crossed = (indexed & coas_pkg::HIGH_MASK)
                                                   != (base & coas_pkg::HIGH_MASK);
                            end
                        end
                    endcase
                end
                default:
                begin
                    st_next.busy = 1'b0;
                    res.status   = coas_pkg::STATUS_ERR;
                end
            endcase
        end
    end

endmodule

// ----- rtl/cpu_operand_address_sequencer.sv -----
// ----------------------------------------------------------------------------
// cpu_operand_address_sequencer
// Effective-address unit for the thirteen addressing modes of an 8-bit CPU.
// ----------------------------------------------------------------------------
// Each input transfer is either a start or a byte of read data, and each one
// produces exactly one result: a bus read request, a done record or an error.
// The unit takes one input transfer per clock cycle and returns its result through
// the input register and then the result register; both advance whenever
// the result register is empty or being taken, so a full result
// stalls the input side only while out_ready is low.
module cpu_operand_address_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [3:0]  mode,
    input  logic [15:0] pc_in,
    input  logic [7:0]  x_index,
    input  logic [7:0]  y_index,
    input  logic [7:0]  read_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] bus_address,
    output logic [15:0] effective_address,
    output logic        address_valid,
    output logic [15:0] next_pc,
    output logic        page_crossed,
    output logic        accumulator_mode
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic                 kind_reg;
    logic [3:0]           mode_reg;
    logic [15:0]          pc_reg;
    logic [7:0]           x_reg;
    logic [7:0]           y_reg;
    logic [7:0]           byte_reg;
    coas_pkg::seq_state_t state_reg;
    coas_pkg::seq_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    coas_pkg::result_t    result_reg;
    coas_pkg::result_t    result_next;
    logic                 advance;
    logic                 load_in;

    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign load_in        = in_valid && in_ready;
    assign in_valid_next  = load_in || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    coas_step u_step
    (
        .st        (state_reg),
        .kind      (kind_reg),
        .mode      (mode_reg),
        .pc_in     (pc_reg),
        .x_index   (x_reg),
        .y_index   (y_reg),
        .read_byte (byte_reg),
        .st_next   (state_next),
        .res       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in) begin
            kind_reg <= kind;
            mode_reg <= mode;
            pc_reg   <= pc_in;
            x_reg    <= x_index;
            y_reg    <= y_index;
            byte_reg <= read_byte;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = result_reg.status;
    assign bus_address       = result_reg.bus_address;
    assign effective_address = result_reg.effective_address;
    assign address_valid     = result_reg.address_valid;
    assign next_pc           = result_reg.next_pc;
    assign page_crossed      = result_reg.page_crossed;
    assign accumulator_mode  = result_reg.accumulator_mode;

endmodule

// ----- rtl/coas_checker.sv -----
// ----------------------------------------------------------------------------
// coas_checker
// Port-level checks of the operand address sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module coas_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] bus_address,
    input logic [15:0] effective_address,
    input logic        address_valid,
    input logic [15:0] next_pc,
    input logic        page_crossed,
    input logic        accumulator_mode
);

    // A stalled result must hold its status and addresses.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(bus_address) && $stable(effective_address))
        else $error("Stalled result changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == coas_pkg::STATUS_REQ
            || status == coas_pkg::STATUS_DONE || status == coas_pkg::STATUS_ERR)
        else $error("Result status code is out of range.");

    // Only done records carry an effective address, a next PC or flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != coas_pkg::STATUS_DONE |-> effective_address == 16'd0
            && next_pc == 16'd0 && !address_valid && !page_crossed && !accumulator_mode)
        else $error("A result that is not done carries done fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != coas_pkg::STATUS_REQ |-> bus_address == 16'd0)
        else $error("A result that is not a request carries a bus address.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (accumulator_mode || page_crossed) |->
            status == coas_pkg::STATUS_DONE && (address_valid != accumulator_mode))
        else $error("Accumulator or page-cross flag is inconsistent.");

endmodule

bind cpu_operand_address_sequencer coas_checker u_coas_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .bus_address       (bus_address),
    .effective_address (effective_address),
    .address_valid     (address_valid),
    .next_pc           (next_pc),
    .page_crossed      (page_crossed),
    .accumulator_mode  (accumulator_mode)
);

// ----- verif/cpu_operand_address_sequencer_tb.sv -----
// ----------------------------------------------------------------------------
// cpu_operand_address_sequencer_tb
// Self-checking testbench for the operand address sequencer.
// ----------------------------------------------------------------------------
// Start and read-data transfers go in as complete addressing sequences for
// every mode, mixed with stray reads, starts while busy and unknown modes.
// A behavioral model predicts one result per accepted input transfer, and
// every result transfer is compared field by field with the oldest
// prediction. The sender works in random bursts, the receiver stalls on a
// shifting pattern, and the run ends once every prediction has been compared.
// ----------------------------------------------------------------------------
module cpu_operand_address_sequencer_tb;

    import coas_pkg::*;

    localparam int          HALF_PERIOD     = 10;
    localparam int          RESET_CYCLES    = 9;
    localparam int          RANDOM_ITEMS    = 1000;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          QUIET_LIMIT     = 2000;
    localparam int          REPORT_LIMIT    = 10;
    localparam logic [3:0]  MODE_UNKNOWN_LO = MODE_INDY + 4'd1;
    localparam logic [3:0]  MODE_UNKNOWN_HI = 4'hF;

    typedef struct packed {
        logic        kind;
        logic [3:0]  mode;
        logic [15:0] pc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  data;
    } seq_input_t;

    class operand_address_checker;
        result_t     expected_results[$];
        int          failures;
        int          starts_in;
        int          reads_in;
        int          requests_seen;
        int          done_seen;
        int          errors_seen;
        logic        busy;
        logic [3:0]  active_mode;
        logic [1:0]  read_step;
        logic [15:0] saved_pc;
        logic [7:0]  saved_x;
        logic [7:0]  saved_y;
        logic [7:0]  low_byte;
        logic [15:0] pointer;

        function new();
            failures      = 0;
            starts_in     = 0;
            reads_in      = 0;
            requests_seen = 0;
            done_seen     = 0;
            errors_seen   = 0;
            busy          = 1'b0;
            active_mode   = MODE_IMP;
            read_step     = STEP_FIRST;
            saved_pc      = '0;
            saved_x       = '0;
            saved_y       = '0;
            low_byte      = '0;
            pointer       = '0;
        endfunction

        function result_t bus_request(input logic [15:0] addr);
            result_t r;
            r             = '0;
            r.status      = STATUS_REQ;
            r.bus_address = addr;
            return r;
        endfunction

        function result_t done_record(input logic [15:0] ea, input logic valid,
                                      input logic [15:0] npc, input logic crossed,
                                      input logic acc);
            result_t r;
            r                   = '0;
            r.status            = STATUS_DONE;
            r.effective_address = ea;
            r.address_valid     = valid;
            r.next_pc           = npc;
            r.page_crossed      = crossed;
            r.accumulator_mode  = acc;
            busy                = 1'b0;
            return r;
        endfunction

        function result_t predict_address_step(input seq_input_t s);
            result_t     r;
            logic [15:0] pc1;
            logic [15:0] pc2;
            logic [15:0] base;
            logic [15:0] target;
            logic [7:0]  zp;
            r        = '0;
            r.status = STATUS_ERR;
            pc1      = saved_pc + 16'd1;
            pc2      = saved_pc + 16'd2;
            if (s.kind == KIND_START) begin
                if (busy || s.mode > MODE_INDY) begin
                    return r;
                end
                case (s.mode)
                    MODE_IMP: return done_record('0, 1'b0, s.pc, 1'b0, 1'b0);
                    MODE_ACC: return done_record('0, 1'b0, s.pc, 1'b0, 1'b1);
                    MODE_IMM: return done_record(s.pc, 1'b1, s.pc + 16'd1, 1'b0, 1'b0);
                    default:
                    begin
                        busy        = 1'b1;
                        active_mode = s.mode;
                        read_step   = STEP_FIRST;
                        saved_pc    = s.pc;
                        saved_x     = s.x;
                        saved_y     = s.y;
                        low_byte    = '0;
                        pointer     = '0;
                        return bus_request(s.pc);
                    end
                endcase
            end
            if (!busy) begin
                return r;
            end
            case (active_mode)
                MODE_ZP:
                    return done_record({8'h00, s.data}, 1'b1, pc1, 1'b0, 1'b0);
                MODE_ZPX, MODE_ZPY:
                begin
                    zp = s.data + ((active_mode == MODE_ZPX) ? saved_x : saved_y);
                    return done_record({8'h00, zp}, 1'b1, pc1, 1'b0, 1'b0);
                end
                MODE_REL:
                begin
                    target = pc1 + {{8{s.data[7]}}, s.data};
                    return done_record(target, 1'b1, pc1, 1'b0, 1'b0);
                end
                MODE_ABS, MODE_ABSX, MODE_ABSY:
                begin
                    if (read_step == STEP_FIRST) begin
                        low_byte  = s.data;
                        read_step = STEP_SECOND;
                        return bus_request(pc1);
                    end
                    base = {s.data, low_byte};
                    if (active_mode == MODE_ABS) begin
                        return done_record(base, 1'b1, pc2, 1'b0, 1'b0);
                    end
                    target = base + {8'h00, (active_mode == MODE_ABSX) ? saved_x : saved_y};
                    return done_record(target, 1'b1, pc2,
                                       (target & HIGH_MASK) != (base & HIGH_MASK), 1'b0);
                end
                MODE_IND:
                begin
                    case (read_step)
                        STEP_FIRST:
                        begin
                            low_byte  = s.data;
                            read_step = STEP_SECOND;
                            return bus_request(pc1);
                        end
                        STEP_SECOND:
                        begin
                            pointer   = {s.data, low_byte};
                            read_step = STEP_THIRD;
                            return bus_request(pointer);
                        end
                        STEP_THIRD:
                        begin
                            low_byte  = s.data;
                            read_step = STEP_FOURTH;
                            return bus_request(pointer + 16'd1);
                        end
                        default:
                            return done_record({s.data, low_byte}, 1'b1, pc2, 1'b0, 1'b0);
                    endcase
                end
                MODE_INDX, MODE_INDY:
                begin
                    if (read_step == STEP_FIRST) begin
                        zp        = (active_mode == MODE_INDX) ? s.data + saved_x : s.data;
                        pointer   = {8'h00, zp};
                        read_step = STEP_SECOND;
                        return bus_request(pointer);
                    end
                    if (read_step == STEP_SECOND) begin
                        low_byte  = s.data;
                        read_step = STEP_THIRD;
                        zp        = pointer[7:0] + 8'd1;
                        return bus_request({8'h00, zp});
                    end
                    base = {s.data, low_byte};
                    if (active_mode == MODE_INDX) begin
                        return done_record(base, 1'b1, pc1, 1'b0, 1'b0);
                    end
                    target = base + {8'h00, saved_y};
                    return done_record(target, 1'b1, pc1,
                                       (target & HIGH_MASK) != (base & HIGH_MASK), 1'b0);
                end
                default:
                begin
                    busy = 1'b0;
                    return r;
                end
            endcase
        endfunction

        function void note_transfer_in(input seq_input_t s);
            if (s.kind == KIND_START) begin
                starts_in++;
            end
            else begin
                reads_in++;
            end
            expected_results.push_back(predict_address_step(s));
        endfunction

        function void check_result(input result_t got);
            result_t want;
            case (got.status)
                STATUS_REQ:  requests_seen++;
                STATUS_DONE: done_seen++;
                default:     errors_seen++;
            endcase
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("unexpected result: status %0d bus %h ea %h av %b npc %h pg %b acc %b",
                             got.status, got.bus_address, got.effective_address,
                             got.address_valid, got.next_pc, got.page_crossed,
                             got.accumulator_mode);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.bus_address !== want.bus_address ||
                got.effective_address !== want.effective_address ||
                got.address_valid !== want.address_valid || got.next_pc !== want.next_pc ||
                got.page_crossed !== want.page_crossed ||
                got.accumulator_mode !== want.accumulator_mode) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("mismatch: expected status %0d bus %h ea %h av %b npc %h pg %b acc %b",
                             want.status, want.bus_address, want.effective_address,
                             want.address_valid, want.next_pc, want.page_crossed,
                             want.accumulator_mode);
                    $display("          actual   status %0d bus %h ea %h av %b npc %h pg %b acc %b",
                             got.status, got.bus_address, got.effective_address,
                             got.address_valid, got.next_pc, got.page_crossed,
                             got.accumulator_mode);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk               = 1'b0;
    logic        rst_n             = 1'b0;
    logic        in_valid          = 1'b0;
    logic        in_ready;
    logic        kind              = KIND_START;
    logic [3:0]  mode              = MODE_IMP;
    logic [15:0] pc_in             = '0;
    logic [7:0]  x_index           = '0;
    logic [7:0]  y_index           = '0;
    logic [7:0]  read_byte         = '0;
    logic        out_valid;
    logic        out_ready         = 1'b0;
    logic [1:0]  status;
    logic [15:0] bus_address;
    logic [15:0] effective_address;
    logic        address_valid;
    logic [15:0] next_pc;
    logic        page_crossed;
    logic        accumulator_mode;

    operand_address_checker tracker;
    seq_input_t             stim_q[$];
    int                     hold_at[$];
    int                     rx_cycle    = 0;
    int                     quiet_count = 0;

    cpu_operand_address_sequencer u_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .mode              (mode),
        .pc_in             (pc_in),
        .x_index           (x_index),
        .y_index           (y_index),
        .read_byte         (read_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .bus_address       (bus_address),
        .effective_address (effective_address),
        .address_valid     (address_valid),
        .next_pc           (next_pc),
        .page_crossed      (page_crossed),
        .accumulator_mode  (accumulator_mode)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {8'($urandom), 8'hFF};
            3:       return {8'hFF, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic seq_input_t start_item(input logic [3:0] m, input logic [15:0] pc,
                                              input logic [7:0] x, input logic [7:0] y);
        seq_input_t s;
        s.kind = KIND_START;
        s.mode = m;
        s.pc   = pc;
        s.x    = x;
        s.y    = y;
        s.data = 8'($urandom);
        return s;
    endfunction

    function automatic seq_input_t read_item(input logic [7:0] b);
        seq_input_t s;
        s.kind = KIND_READ;
        s.mode = 4'($urandom);
        s.pc   = 16'($urandom);
        s.x    = 8'($urandom);
        s.y    = 8'($urandom);
        s.data = b;
        return s;
    endfunction

    function automatic int reads_needed(input logic [3:0] m);
        case (m)
            MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL: return 1;
            MODE_ABS, MODE_ABSX, MODE_ABSY:        return 2;
            MODE_INDX, MODE_INDY:                  return 3;
            MODE_IND:                              return 4;
            default:                               return 0;
        endcase
    endfunction

    task automatic add_sequence(input logic [3:0] m, input bit intrude);
        int n;
        int intrude_at;
        n          = reads_needed(m);
        intrude_at = (n > 0) ? $urandom_range(0, n - 1) : -1;
        stim_q.push_back(start_item(m, rand_word(), rand_byte(), rand_byte()));
        for (int i = 0; i < n; i++) begin
            if (intrude && i == intrude_at) begin
                stim_q.push_back(start_item(4'($urandom), rand_word(), rand_byte(),
                                            rand_byte()));
            end
            stim_q.push_back(read_item(rand_byte()));
        end
    endtask

    task automatic build_stimulus();
        int pick;
        int stop_at;
        stim_q.push_back(read_item(8'hA5));
        stim_q.push_back(start_item(MODE_IMP, 16'hFFFF, 8'h00, 8'hFF));
        stim_q.push_back(start_item(MODE_ACC, 16'h0000, 8'hFF, 8'h00));
        stim_q.push_back(start_item(MODE_IMM, 16'hFFFF, 8'h12, 8'h34));
        stim_q.push_back(start_item(MODE_ZPX, 16'hFFFF, 8'hFF, 8'h00));
        stim_q.push_back(read_item(8'hFF));
        stim_q.push_back(start_item(MODE_REL, 16'h00FF, 8'h00, 8'h00));
        stim_q.push_back(read_item(8'h80));
        stim_q.push_back(start_item(MODE_ABSX, 16'hFFFE, 8'hFF, 8'h00));
        stim_q.push_back(read_item(8'h01));
        stim_q.push_back(read_item(8'h12));
        stim_q.push_back(start_item(MODE_IND, 16'h1234, 8'h00, 8'h00));
        stim_q.push_back(read_item(8'hFF));
        stim_q.push_back(read_item(8'hFF));
        stim_q.push_back(read_item(8'h34));
        stim_q.push_back(read_item(8'h56));
        stim_q.push_back(start_item(MODE_INDY, 16'h8000, 8'h00, 8'hFF));
        stim_q.push_back(read_item(8'hFF));
        stim_q.push_back(start_item(MODE_ZP, 16'h4000, 8'h00, 8'h00));
        stim_q.push_back(read_item(8'h80));
        stim_q.push_back(read_item(8'h7F));
        stim_q.push_back(start_item(MODE_UNKNOWN_LO, 16'h0000, 8'h00, 8'h00));
        stim_q.push_back(start_item(MODE_UNKNOWN_HI, 16'hFFFF, 8'hFF, 8'hFF));

        hold_at.push_back(stim_q.size());
        hold_at.push_back(stim_q.size() + RANDOM_ITEMS / 2);
        stop_at = stim_q.size() + RANDOM_ITEMS;
        while (stim_q.size() < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                add_sequence(4'($urandom_range(MODE_IMP, MODE_INDY)), 1'b0);
            end
            else if (pick < 91) begin
                add_sequence(4'($urandom_range(MODE_ZP, MODE_INDY)), 1'b1);
            end
            else if (pick < 96) begin
                stim_q.push_back(read_item(rand_byte()));
            end
            else begin
                stim_q.push_back(start_item(4'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI)),
                                            rand_word(), rand_byte(), rand_byte()));
            end
        end
    endtask

    task automatic drive_stimulus();
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 24);
        for (int idx = 0; idx < stim_q.size(); idx++) begin
            if (hold_at.size() != 0 && hold_at[0] == idx) begin
                hold_at.delete(0);
                in_valid <= 1'b0;
                @(posedge clk);
                while (tracker.pending() != 0) @(posedge clk);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 12);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid  <= 1'b1;
            kind      <= stim_q[idx].kind;
            mode      <= stim_q[idx].mode;
            pc_in     <= stim_q[idx].pc;
            x_index   <= stim_q[idx].x;
            y_index   <= stim_q[idx].y;
            read_byte <= stim_q[idx].data;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            tracker.note_transfer_in(stim_q[idx]);
        end
        in_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready) begin
            tracker.check_result({status, bus_address, effective_address, address_valid,
                                  next_pc, page_crossed, accumulator_mode});
        end
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= ((rx_cycle % 7) >= 3);
            default: out_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_count <= 0;
        end
        else if (quiet_count >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("[cpu_operand_address_sequencer] ERROR");
            $finish;
        end
        else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial
    begin
        tracker = new();
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_stimulus();
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d start and %0d read-data transfers across all addressing modes",
                 tracker.starts_in, tracker.reads_in);
        $display("results: %0d bus requests, %0d done records, %0d error records, %0d failures",
                 tracker.requests_seen, tracker.done_seen, tracker.errors_seen,
                 tracker.failures);
        if (tracker.failures == 0) begin
            $display("[cpu_operand_address_sequencer] OK");
        end
        else begin
            $display("[cpu_operand_address_sequencer] ERROR");
        end
        $finish;
    end

endmodule
